/* design/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* design/flsa_pkg.sv */
// Shared constants and types of the free list segment allocator.
package flsa_pkg;

    localparam int MEM_WORDS    = 65536;
    localparam int MAX_SEGMENTS = 64;
    localparam int ADDR_W       = 16;
    localparam int SIZE_W       = 17;
    localparam int END_W        = 18;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;

    localparam logic FIT_FIRST = 1'b0;
    localparam logic FIT_BEST  = 1'b1;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Operation broadcast to every cell of the table.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ROT,
        CELL_DEL,
        CELL_INS,
        CELL_WR
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [CNT_W-1:0]  k;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
    } t_cell_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_CARVE,
        S_GB_SCAN,
        S_GB_APPLY,
        S_GB_DEL,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        PH_ALLOC_P,
        PH_ALLOC_S,
        PH_FREE_P,
        PH_FREE_S,
        PH_ROLLBACK
    } t_phase;

endpackage

/* design/free_list_segment_allocator_top.sv */
// Free list segment allocator: sequencer, configuration and result register.
//
// The free table lives in a ring of MAX_SEGMENTS cells. Every lookup rotates
// the ring once, one entry past the head per cycle; a carve, merge or insert
// then rewrites or shifts the row, with a separate delete step when a merge
// joins both neighbors. An allocate takes two scans, or one scan when the
// program segment does not fit, plus one more scan when the stack does not
// fit and the program segment is returned. A free takes two scans, one per
// half. One item is worked on at a time; the next is accepted while the
// previous result still waits in the output register. fit_mode may be
// written at any time the block is idle; o_cfg_ready is always high.
module free_list_segment_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [16:0] i_prog_size,
    input  logic [16:0] i_stack_size,
    input  logic [15:0] i_prog_start,
    input  logic [15:0] i_stack_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_prog_base,
    output logic [15:0] o_stack_base,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_fit_mode
);

`include "assert_macros.svh"

    localparam int A = flsa_pkg::ADDR_W;
    localparam int S = flsa_pkg::SIZE_W;
    localparam int C = flsa_pkg::CNT_W;
    localparam int I = flsa_pkg::IDX_W;
    localparam int E = flsa_pkg::END_W;

    flsa_pkg::t_state r_state, n_state;
    flsa_pkg::t_phase r_phase, n_phase;

    logic [I-1:0] r_j, n_j;
    logic [C-1:0] r_count, n_count;
    logic         r_fit_mode;

    logic [S-1:0] r_psize, n_psize, r_ssize, n_ssize;
    logic [A-1:0] r_pstart, n_pstart, r_sstart, n_sstart;
    logic [A-1:0] r_pbase, n_pbase, r_sbase, n_sbase;
    logic [1:0]   r_stat, n_stat;

    logic         r_hit, n_hit;
    logic [C-1:0] r_sel_k, n_sel_k;
    logic [A-1:0] r_sel_first, n_sel_first, r_sel_last, n_sel_last;
    logic [S-1:0] r_sel_len, n_sel_len;

    logic [C-1:0] r_p, n_p;
    logic [A-1:0] r_prev_first, n_prev_first, r_prev_last, n_prev_last;
    logic         r_has_next, n_has_next;
    logic [A-1:0] r_next_first, n_next_first, r_next_last, n_next_last;

    logic         r_out_valid, n_out_valid;
    logic [1:0]   r_o_status, n_o_status;
    logic [A-1:0] r_o_pbase, n_o_pbase, r_o_sbase, n_o_sbase;

    flsa_pkg::t_cell_cmd cell_cmd;
    logic [A-1:0]        head_first, head_last;

    logic [S-1:0] cur_size, head_len;
    logic [A-1:0] cur_start, gb_end;
    logic [E-1:0] end_ext;
    logic         head_valid, scan_last, fits, take, scan_clr, gb_done;
    logic         gb_bad, has_prev, ovl_l, ovl_r, join_l, join_r;

    flsa_row u_row (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cell_cmd),
        .o_head_first (head_first),
        .o_head_last  (head_last)
    );

    // Operands of the current phase and the entry now at the head of the ring.
    always_comb begin
        unique case (r_phase) inside
            flsa_pkg::PH_ALLOC_P, flsa_pkg::PH_FREE_P, flsa_pkg::PH_ROLLBACK: begin
                cur_size = r_psize;
            end
            default: begin
                cur_size = r_ssize;
            end
        endcase
        unique case (r_phase)
            flsa_pkg::PH_FREE_P: cur_start = r_pstart;
            flsa_pkg::PH_FREE_S: cur_start = r_sstart;
            default:             cur_start = r_pbase;
        endcase
        head_valid = C'(r_j) < r_count;
        scan_last  = r_j == I'(flsa_pkg::MAX_SEGMENTS - 1);
        head_len   = S'(head_last) - S'(head_first) + S'(1);
        fits       = head_valid && (cur_size != '0) && (head_len >= cur_size);
        take       = fits && (!r_hit ||
                     (r_fit_mode == flsa_pkg::FIT_BEST && head_len < r_sel_len));
    end

    // Checks of a returned segment against its neighbors.
    always_comb begin
        end_ext  = E'(cur_start) + E'(cur_size) - E'(1);
        gb_end   = end_ext[A-1:0];
        gb_bad   = (cur_size == '0) || (end_ext > E'(flsa_pkg::MEM_WORDS - 1));
        has_prev = r_p != '0;
        ovl_l    = has_prev && (r_prev_last >= cur_start);
        ovl_r    = r_has_next && (r_next_first <= gb_end);
        join_l   = has_prev && ((S'(r_prev_last) + S'(1)) == S'(cur_start));
        join_r   = r_has_next && ((S'(gb_end) + S'(1)) == S'(r_next_first));
    end

    // Sequencer: next state, table commands and bookkeeping.
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_j          = r_j;
        n_count      = r_count;
        n_psize      = r_psize;
        n_ssize      = r_ssize;
        n_pstart     = r_pstart;
        n_sstart     = r_sstart;
        n_pbase      = r_pbase;
        n_sbase      = r_sbase;
        n_stat       = r_stat;
        n_hit        = r_hit;
        n_sel_k      = r_sel_k;
        n_sel_first  = r_sel_first;
        n_sel_last   = r_sel_last;
        n_sel_len    = r_sel_len;
        n_p          = r_p;
        n_prev_first = r_prev_first;
        n_prev_last  = r_prev_last;
        n_has_next   = r_has_next;
        n_next_first = r_next_first;
        n_next_last  = r_next_last;
        n_out_valid  = r_out_valid;
        n_o_status   = r_o_status;
        n_o_pbase    = r_o_pbase;
        n_o_sbase    = r_o_sbase;
        cell_cmd     = '{op: flsa_pkg::CELL_HOLD, k: '0, first: '0, last: '0};
        scan_clr     = 1'b0;
        gb_done      = 1'b0;

        // The result beat leaves when the receiver is not stalling.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            flsa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_psize  = i_prog_size;
                    n_ssize  = i_stack_size;
                    n_pstart = i_prog_start;
                    n_sstart = i_stack_start;
                    n_pbase  = '0;
                    n_sbase  = '0;
                    n_stat   = flsa_pkg::ST_OK;
                    scan_clr = 1'b1;
                    if (i_action == flsa_pkg::ACT_ALLOC) begin
                        n_phase = flsa_pkg::PH_ALLOC_P;
                        n_state = flsa_pkg::S_PICK;
                    end else begin
                        n_phase = flsa_pkg::PH_FREE_P;
                        n_state = flsa_pkg::S_GB_SCAN;
                    end
                end
            end
            flsa_pkg::S_PICK: begin
                cell_cmd.op = flsa_pkg::CELL_ROT;
                n_j = r_j + I'(1);
                if (take) begin
                    n_hit       = 1'b1;
                    n_sel_k     = C'(r_j);
                    n_sel_first = head_first;
                    n_sel_last  = head_last;
                    n_sel_len   = head_len;
                end
                if (scan_last) begin
                    n_j = '0;
                    if (n_hit) begin
                        n_state = flsa_pkg::S_CARVE;
                    end else if (r_phase == flsa_pkg::PH_ALLOC_P) begin
                        n_stat  = flsa_pkg::ST_NO_SPACE;
                        n_state = flsa_pkg::S_DONE;
                    end else begin
                        n_phase  = flsa_pkg::PH_ROLLBACK;
                        n_state  = flsa_pkg::S_GB_SCAN;
                        scan_clr = 1'b1;
                    end
                end
            end
            flsa_pkg::S_CARVE: begin
                // An exact fit removes the entry, otherwise its low end moves up.
                if (r_sel_len == cur_size) begin
                    cell_cmd.op = flsa_pkg::CELL_DEL;
                    cell_cmd.k  = r_sel_k;
                    n_count     = r_count - C'(1);
                end else begin
                    cell_cmd.op    = flsa_pkg::CELL_WR;
                    cell_cmd.k     = r_sel_k;
                    cell_cmd.first = r_sel_first + cur_size[A-1:0];
                    cell_cmd.last  = r_sel_last;
                end
                if (r_phase == flsa_pkg::PH_ALLOC_P) begin
                    n_pbase  = r_sel_first;
                    n_phase  = flsa_pkg::PH_ALLOC_S;
                    n_state  = flsa_pkg::S_PICK;
                    scan_clr = 1'b1;
                end else begin
                    n_sbase = r_sel_first;
                    n_state = flsa_pkg::S_DONE;
                end
            end
            flsa_pkg::S_GB_SCAN: begin
                cell_cmd.op = flsa_pkg::CELL_ROT;
                n_j = r_j + I'(1);
                // Find the insertion point and both neighbors of the segment.
                if (head_valid) begin
                    if (head_first <= cur_start) begin
                        n_p          = C'(r_j) + C'(1);
                        n_prev_first = head_first;
                        n_prev_last  = head_last;
                    end else if (!r_has_next) begin
                        n_has_next   = 1'b1;
                        n_next_first = head_first;
                        n_next_last  = head_last;
                    end
                end
                if (scan_last) begin
                    n_j     = '0;
                    n_state = flsa_pkg::S_GB_APPLY;
                end
            end
            flsa_pkg::S_GB_APPLY: begin
                gb_done = 1'b1;
                if (gb_bad || ovl_l || ovl_r) begin
                    cell_cmd.op = flsa_pkg::CELL_HOLD;
                end else if (join_l && join_r) begin
                    cell_cmd.op    = flsa_pkg::CELL_WR;
                    cell_cmd.k     = r_p - C'(1);
                    cell_cmd.first = r_prev_first;
                    cell_cmd.last  = r_next_last;
                    gb_done        = 1'b0;
                    n_state        = flsa_pkg::S_GB_DEL;
                end else if (join_l) begin
                    cell_cmd.op    = flsa_pkg::CELL_WR;
                    cell_cmd.k     = r_p - C'(1);
                    cell_cmd.first = r_prev_first;
                    cell_cmd.last  = gb_end;
                end else if (join_r) begin
                    cell_cmd.op    = flsa_pkg::CELL_WR;
                    cell_cmd.k     = r_p;
                    cell_cmd.first = cur_start;
                    cell_cmd.last  = r_next_last;
                end else if (r_count >= C'(flsa_pkg::MAX_SEGMENTS)) begin
                    n_stat = flsa_pkg::ST_TABLE_FULL;
                end else begin
                    cell_cmd.op    = flsa_pkg::CELL_INS;
                    cell_cmd.k     = r_p;
                    cell_cmd.first = cur_start;
                    cell_cmd.last  = gb_end;
                    n_count        = r_count + C'(1);
                end
            end
            flsa_pkg::S_GB_DEL: begin
                cell_cmd.op = flsa_pkg::CELL_DEL;
                cell_cmd.k  = r_p;
                n_count     = r_count - C'(1);
                gb_done     = 1'b1;
            end
            flsa_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_stat;
                    n_o_pbase   = r_pbase;
                    n_o_sbase   = r_sbase;
                    n_state     = flsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = flsa_pkg::S_IDLE;
            end
        endcase

        // After a segment has been returned, move on to the next step.
        if (gb_done) begin
            unique case (r_phase)
                flsa_pkg::PH_FREE_P: begin
                    n_phase  = flsa_pkg::PH_FREE_S;
                    n_state  = flsa_pkg::S_GB_SCAN;
                    scan_clr = 1'b1;
                end
                flsa_pkg::PH_ROLLBACK: begin
                    n_pbase = '0;
                    n_stat  = flsa_pkg::ST_NO_SPACE;
                    n_state = flsa_pkg::S_DONE;
                end
                default: begin
                    n_state = flsa_pkg::S_DONE;
                end
            endcase
        end

        // Fresh search state for the next scan.
        if (scan_clr) begin
            n_hit      = 1'b0;
            n_p        = '0;
            n_has_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= flsa_pkg::S_IDLE;
            r_phase     <= flsa_pkg::PH_ALLOC_P;
            r_j         <= '0;
            r_count     <= C'(1);
            r_fit_mode  <= flsa_pkg::FIT_FIRST;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
            r_has_next  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_j         <= n_j;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_hit       <= n_hit;
            r_has_next  <= n_has_next;
            if (i_cfg_valid) begin
                r_fit_mode <= i_cfg_fit_mode;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_psize      <= n_psize;
        r_ssize      <= n_ssize;
        r_pstart     <= n_pstart;
        r_sstart     <= n_sstart;
        r_pbase      <= n_pbase;
        r_sbase      <= n_sbase;
        r_stat       <= n_stat;
        r_sel_k      <= n_sel_k;
        r_sel_first  <= n_sel_first;
        r_sel_last   <= n_sel_last;
        r_sel_len    <= n_sel_len;
        r_p          <= n_p;
        r_prev_first <= n_prev_first;
        r_prev_last  <= n_prev_last;
        r_next_first <= n_next_first;
        r_next_last  <= n_next_last;
        r_o_status   <= n_o_status;
        r_o_pbase    <= n_o_pbase;
        r_o_sbase    <= n_o_sbase;
    end

    assign o_in_stall   = r_state != flsa_pkg::S_IDLE;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_o_status;
    assign o_prog_base  = r_o_pbase;
    assign o_stack_base = r_o_sbase;
    assign o_cfg_ready  = 1'b1;

    // The table never holds more entries than there are cells.
    `ASSERT_ALWAYS(a_count_bound, r_count <= C'(flsa_pkg::MAX_SEGMENTS),
        "free table count beyond cell count")
    // Outside a scan the ring must sit at its home position.
    `ASSERT_IMPLY(a_ring_home,
        r_state != flsa_pkg::S_PICK && r_state != flsa_pkg::S_GB_SCAN, r_j == '0,
        "cell ring left a scan out of alignment")
    // A result that is not ok carries no granted base.
    `ASSERT_IMPLY(a_fail_bases, o_out_valid && o_status != flsa_pkg::ST_OK,
        o_prog_base == '0 && o_stack_base == '0, "failed request returned a base")
    // The count moves by at most one entry per cycle.
    `ASSERT_ALWAYS(a_count_step,
        r_count == $past(r_count) || r_count == $past(r_count) + C'(1) ||
        r_count == $past(r_count) - C'(1), "free table count jumped")

endmodule

/* design/flsa_cell.sv */
// One cell of the free table: holds one segment and trades it with its neighbors.
module flsa_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  flsa_pkg::t_cell_cmd          i_cmd,
    input  logic [flsa_pkg::CNT_W-1:0]   i_idx,
    input  logic [flsa_pkg::ADDR_W-1:0]  i_right_first,
    input  logic [flsa_pkg::ADDR_W-1:0]  i_right_last,
    input  logic [flsa_pkg::ADDR_W-1:0]  i_left_first,
    input  logic [flsa_pkg::ADDR_W-1:0]  i_left_last,
    output logic [flsa_pkg::ADDR_W-1:0]  o_first,
    output logic [flsa_pkg::ADDR_W-1:0]  o_last
);

    logic [flsa_pkg::ADDR_W-1:0] r_first, n_first;
    logic [flsa_pkg::ADDR_W-1:0] r_last,  n_last;

    // Select the next contents from the broadcast operation.
    always_comb begin
        n_first = r_first;
        n_last  = r_last;
        unique case (i_cmd.op)
            flsa_pkg::CELL_ROT: begin
                n_first = i_right_first;
                n_last  = i_right_last;
            end
            flsa_pkg::CELL_DEL: begin
                if (i_idx >= i_cmd.k) begin
                    n_first = i_right_first;
                    n_last  = i_right_last;
                end
            end
            flsa_pkg::CELL_INS: begin
                if (i_idx > i_cmd.k) begin
                    n_first = i_left_first;
                    n_last  = i_left_last;
                end else if (i_idx == i_cmd.k) begin
                    n_first = i_cmd.first;
                    n_last  = i_cmd.last;
                end
            end
            flsa_pkg::CELL_WR: begin
                if (i_idx == i_cmd.k) begin
                    n_first = i_cmd.first;
                    n_last  = i_cmd.last;
                end
            end
            default: begin
            end
        endcase
    end

    // Every cell resets to the whole memory; only the first one counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_last  <= flsa_pkg::ADDR_W'(flsa_pkg::MEM_WORDS - 1);
        end else begin
            r_first <= n_first;
            r_last  <= n_last;
        end
    end

    assign o_first = r_first;
    assign o_last  = r_last;

endmodule

/* design/flsa_row.sv */
// The row of table cells, wired as a ring for scanning and a line for shifting.
module flsa_row (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  flsa_pkg::t_cell_cmd          i_cmd,
    output logic [flsa_pkg::ADDR_W-1:0]  o_head_first,
    output logic [flsa_pkg::ADDR_W-1:0]  o_head_last
);

    logic [flsa_pkg::ADDR_W-1:0] cell_first [flsa_pkg::MAX_SEGMENTS];
    logic [flsa_pkg::ADDR_W-1:0] cell_last  [flsa_pkg::MAX_SEGMENTS];

    // Each cell sees its right neighbor (ring wrap) and its left neighbor.
    for (genvar gi = 0; gi < flsa_pkg::MAX_SEGMENTS; gi++) begin : g_cell
        localparam int RIGHT = (gi + 1) % flsa_pkg::MAX_SEGMENTS;
        localparam int LEFT  = (gi == 0) ? 0 : gi - 1;
        flsa_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (i_cmd),
            .i_idx         (flsa_pkg::CNT_W'(gi)),
            .i_right_first (cell_first[RIGHT]),
            .i_right_last  (cell_last[RIGHT]),
            .i_left_first  (cell_first[LEFT]),
            .i_left_last   (cell_last[LEFT]),
            .o_first       (cell_first[gi]),
            .o_last        (cell_last[gi])
        );
    end

    assign o_head_first = cell_first[0];
    assign o_head_last  = cell_last[0];

endmodule

/* bench/tb_free_list_segment_allocator_top.sv */
// Self-checking testbench for the free list segment allocator top level.
module tb_free_list_segment_allocator_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    typedef struct {
        logic        action;
        logic [16:0] prog_size;
        logic [16:0] stack_size;
        logic [15:0] prog_start;
        logic [15:0] stack_start;
    } t_req;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] prog_base;
        logic [15:0] stack_base;
    } t_grant;

    typedef struct {
        int unsigned start;
        int unsigned size;
    } t_seg;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_action;
    logic [16:0] i_prog_size;
    logic [16:0] i_stack_size;
    logic [15:0] i_prog_start;
    logic [15:0] i_stack_start;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic [15:0] o_prog_base;
    logic [15:0] o_stack_base;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_fit_mode;

    free_list_segment_allocator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_prog_size    (i_prog_size),
        .i_stack_size   (i_stack_size),
        .i_prog_start   (i_prog_start),
        .i_stack_start  (i_stack_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_prog_base    (o_prog_base),
        .o_stack_base   (o_stack_base),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_fit_mode (i_cfg_fit_mode)
    );

    // Shadow copy of the free table and the placement rule.
    int unsigned free_lo [flsa_pkg::MAX_SEGMENTS];
    int unsigned free_hi [flsa_pkg::MAX_SEGMENTS];
    int unsigned free_cnt;
    logic        fit_rule;

    t_grant pending_grants[$];
    t_seg   live_segs[$];
    int     error_count;
    int     idle_cycles;
    int     burst_left;

    // Free-running clock with a 4 ns period.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int find_fit(int unsigned sz);
        int          chosen;
        int unsigned chosen_len;
        int unsigned len;
        chosen = -1;
        chosen_len = 0;
        if (sz == 0) return -1;
        for (int i = 0; i < free_cnt; i++) begin
            len = free_hi[i] - free_lo[i] + 1;
            if (len < sz) continue;
            if (fit_rule == flsa_pkg::FIT_FIRST) return i;
            if (chosen < 0 || len < chosen_len) begin
                chosen = i;
                chosen_len = len;
            end
        end
        return chosen;
    endfunction

    function automatic void remove_entry(int unsigned k);
        for (int unsigned j = k; j + 1 < free_cnt; j++) begin
            free_lo[j] = free_lo[j + 1];
            free_hi[j] = free_hi[j + 1];
        end
        free_cnt--;
    endfunction

    // Takes sz words from the low end of entry k and returns their base.
    function automatic int unsigned take_words(int unsigned k, int unsigned sz);
        int unsigned base;
        base = free_lo[k];
        if (free_hi[k] - base + 1 == sz) remove_entry(k);
        else free_lo[k] = base + sz;
        return base;
    endfunction

    // Returns a segment to the table; zero only when the table is full.
    function automatic bit return_words(int unsigned start, int unsigned sz);
        int unsigned last;
        int unsigned p;
        bit          join_l;
        bit          join_r;
        p = 0;
        if (sz == 0 || start >= flsa_pkg::MEM_WORDS) return 1'b1;
        last = start + sz - 1;
        if (last > flsa_pkg::MEM_WORDS - 1) return 1'b1;
        while (p < free_cnt && free_lo[p] <= start) p++;
        if (p > 0 && free_hi[p - 1] >= start) return 1'b1;
        if (p < free_cnt && free_lo[p] <= last) return 1'b1;
        join_l = (p > 0) && (free_hi[p - 1] + 1 == start);
        join_r = (p < free_cnt) && (last + 1 == free_lo[p]);
        if (join_l && join_r) begin
            free_hi[p - 1] = free_hi[p];
            remove_entry(p);
        end else if (join_l) begin
            free_hi[p - 1] = last;
        end else if (join_r) begin
            free_lo[p] = start;
        end else begin
            if (free_cnt >= flsa_pkg::MAX_SEGMENTS) return 1'b0;
            for (int unsigned j = free_cnt; j > p; j--) begin
                free_lo[j] = free_lo[j - 1];
                free_hi[j] = free_hi[j - 1];
            end
            free_lo[p] = start;
            free_hi[p] = last;
            free_cnt++;
        end
        return 1'b1;
    endfunction

    // Drops tracked segments that a new grant overlaps.
    function automatic void forget_overlaps(int unsigned start, int unsigned sz);
        for (int i = live_segs.size() - 1; i >= 0; i--)
            if (live_segs[i].start < start + sz && start < live_segs[i].start + live_segs[i].size)
                live_segs.delete(i);
    endfunction

    function automatic t_grant predict_grant(t_req r);
        t_grant g;
        int     idx;
        bit     ok_p;
        bit     ok_s;
        g = '{flsa_pkg::ST_OK, 16'd0, 16'd0};
        if (r.action == flsa_pkg::ACT_ALLOC) begin
            idx = find_fit(r.prog_size);
            if (idx < 0) begin
                g.status = flsa_pkg::ST_NO_SPACE;
            end else begin
                g.prog_base = 16'(take_words(idx, r.prog_size));
                idx = find_fit(r.stack_size);
                if (idx < 0) begin
                    void'(return_words(g.prog_base, r.prog_size));
                    g.prog_base = 16'd0;
                    g.status = flsa_pkg::ST_NO_SPACE;
                end else begin
                    g.stack_base = 16'(take_words(idx, r.stack_size));
                end
            end
        end else begin
            ok_p = return_words(r.prog_start, r.prog_size);
            ok_s = return_words(r.stack_start, r.stack_size);
            if (!ok_p || !ok_s) g.status = flsa_pkg::ST_TABLE_FULL;
        end
        return g;
    endfunction

    // Sends one request beat, with bursts and gaps, and queues its expectation.
    task automatic send_req(t_req r, output t_grant g);
        @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_action      = r.action;
        i_prog_size   = r.prog_size;
        i_stack_size  = r.stack_size;
        i_prog_start  = r.prog_start;
        i_stack_start = r.stack_start;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        g = predict_grant(r);
        pending_grants.push_back(g);
        if (r.action == flsa_pkg::ACT_ALLOC && g.status == flsa_pkg::ST_OK) begin
            forget_overlaps(g.prog_base, r.prog_size);
            forget_overlaps(g.stack_base, r.stack_size);
            live_segs.push_back('{g.prog_base, r.prog_size});
            live_segs.push_back('{g.stack_base, r.stack_size});
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic send_alloc(int unsigned psz, int unsigned ssz, output t_grant g);
        send_req('{flsa_pkg::ACT_ALLOC, psz[16:0], ssz[16:0], 16'($urandom),
                   16'($urandom)}, g);
    endtask

    task automatic send_free(int unsigned ps, int unsigned psz, int unsigned ss,
                             int unsigned ssz);
        t_grant g;
        send_req('{flsa_pkg::ACT_FREE, psz[16:0], ssz[16:0], ps[15:0], ss[15:0]}, g);
    endtask

    // Ends any open burst, then waits until every expected result has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_fit_rule(logic m);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid    = 1'b1;
        i_cfg_fit_mode = m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        fit_rule = m;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Returns every tracked segment, two per beat.
    task automatic free_all_live();
        t_seg a;
        t_seg b;
        while (live_segs.size() != 0) begin
            a = live_segs.pop_front();
            if (live_segs.size() != 0) b = live_segs.pop_front();
            else b = '{16'($urandom), 0};
            send_free(a.start, a.size, b.start, b.size);
        end
    endtask

    // Zero sizes, oversize requests, rollback, double and invalid frees.
    task automatic test_corner_cases();
        t_grant g;
        send_alloc(0, 5, g);
        send_alloc(5, 0, g);
        send_alloc(65536, 1, g);
        send_alloc(1, 65536, g);
        send_alloc(1, 1, g);
        send_alloc(100, 200, g);
        send_alloc(65536, 65536, g);
        send_free(500, 10, 65535, 2);
        send_free(70000 & 16'hFFFF, 0, 0, 0);
        send_free(65535, 1, 0, 65536);
        send_free(0, 1, 1, 1);
        send_alloc(1, 1, g);
        send_alloc(32768, 16, g);
        send_alloc(40000, 1, g);
        free_all_live();
        send_alloc(65535, 1, g);
        free_all_live();
        send_alloc(65536, 0, g);
    endtask

    // Fragments the memory into isolated words until the table overflows.
    task automatic test_table_full();
        t_grant g;
        int unsigned pbase [70];
        int unsigned sbase [70];
        free_all_live();
        for (int i = 0; i < 70; i++) begin
            send_alloc(1, 1, g);
            pbase[i] = g.prog_base;
            sbase[i] = g.stack_base;
        end
        live_segs.delete();
        for (int i = 0; i < 70; i++) send_free(pbase[i], 1, 16'($urandom), 0);
        for (int i = 0; i < 70; i++) send_free(sbase[i], 1, pbase[i], 1);
    endtask

    // Holes of several sizes so that the placement rules choose differently.
    task automatic test_best_fit();
        t_grant g;
        int unsigned base [6];
        free_all_live();
        for (int i = 0; i < 6; i++) begin
            send_alloc(10 * (6 - i), 1, g);
            base[i] = g.prog_base;
        end
        for (int i = 0; i < 6; i += 2) send_free(base[i], 10 * (6 - i), 0, 0);
        send_alloc(15, 15, g);
        send_alloc(20, 20, g);
    endtask

    // Mostly well-formed allocate and free traffic with some noise mixed in.
    task automatic test_random_traffic(int n);
        t_grant g;
        t_seg   a;
        t_seg   b;
        int     pick;
        int unsigned psz;
        int unsigned ssz;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_free($urandom, $urandom_range(0, 65536), $urandom,
                          $urandom_range(0, 65536));
            end else if (live_segs.size() >= 2 && (pick < 50 || live_segs.size() > 120)) begin
                a = live_segs[$urandom_range(0, live_segs.size() - 1)];
                forget_overlaps(a.start, a.size);
                if ($urandom_range(0, 4) == 0 || live_segs.size() == 0) begin
                    b = '{16'($urandom), 0};
                end else begin
                    b = live_segs[$urandom_range(0, live_segs.size() - 1)];
                    forget_overlaps(b.start, b.size);
                end
                send_free(a.start, a.size, b.start, b.size);
            end else begin
                pick = $urandom_range(0, 99);
                psz = (pick < 85) ? $urandom_range(1, 1500) :
                      (pick < 95) ? $urandom_range(1, 65536) : 65536;
                pick = $urandom_range(0, 99);
                ssz = (pick < 85) ? $urandom_range(1, 1500) :
                      (pick < 95) ? $urandom_range(0, 65536) : 0;
                send_alloc(psz, ssz, g);
            end
        end
    endtask

    // Result checker: each beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_grant exp_g;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_grants.size() == 0) begin
                $error("unexpected result beat: status %0d", o_status);
                error_count++;
            end else begin
                exp_g = pending_grants.pop_front();
                if (o_status !== exp_g.status) begin
                    $error("status: expected %0d actual %0d", exp_g.status, o_status);
                    error_count++;
                end
                if (o_prog_base !== exp_g.prog_base) begin
                    $error("prog_base: expected %0d actual %0d", exp_g.prog_base, o_prog_base);
                    error_count++;
                end
                if (o_stack_base !== exp_g.stack_base) begin
                    $error("stack_base: expected %0d actual %0d", exp_g.stack_base,
                           o_stack_base);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall pattern: calm, light and heavy stretches.
    initial begin
        int mode;
        int span;
        i_out_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 400);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0: begin
                        i_out_stall = 1'b0;
                    end
                    1: begin
                        i_out_stall = ($urandom_range(0, 9) < 3);
                    end
                    default: begin
                        i_out_stall = ($urandom_range(0, 9) < 8);
                    end
                endcase
            end
        end
    end

    // Watchdog on cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_action       = flsa_pkg::ACT_ALLOC;
        i_prog_size    = '0;
        i_stack_size   = '0;
        i_prog_start   = '0;
        i_stack_start  = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_fit_mode = flsa_pkg::FIT_FIRST;
        error_count    = 0;
        idle_cycles    = 0;
        burst_left     = 0;
        free_lo        = '{default: 0};
        free_hi        = '{default: 0};
        free_hi[0]     = flsa_pkg::MEM_WORDS - 1;
        free_cnt       = 1;
        fit_rule       = flsa_pkg::FIT_FIRST;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_corner_cases();
        test_table_full();
        write_fit_rule(flsa_pkg::FIT_BEST);
        test_best_fit();
        test_table_full();
        test_random_traffic(350);
        write_fit_rule(flsa_pkg::FIT_FIRST);
        test_best_fit();
        test_random_traffic(350);
        write_fit_rule(flsa_pkg::FIT_BEST);
        test_random_traffic(350);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_grants.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/flsa_pkg.sv
design/flsa_cell.sv
design/flsa_row.sv
design/free_list_segment_allocator_top.sv
bench/tb_free_list_segment_allocator_top.sv
